// ===== sv/ocrc_pkg.sv =====
// ----------------------------------------------------------------------------
// ocrc_pkg: shared types and constants of the 1-Wire frame CRC checker
// Holds the Dallas CRC-8 byte update, the frame length constants, the
// status codes and the result record that travels to the output register.
// ----------------------------------------------------------------------------
package ocrc_pkg;

	// Reflected Dallas/Maxim CRC-8 polynomial.
	localparam logic [7:0] CRC_POLY = 8'h8C;

	// Byte index of the check byte in each frame type, and the idle mark.
	localparam logic [3:0] ROM_LAST   = 4'd7;
	localparam logic [3:0] PAD_LAST   = 4'd8;
	localparam logic [3:0] IDLE_INDEX = 4'd9;

	// Bit 0 of byte 0 is forced to this for the repaired check.
	localparam logic [7:0] REPAIR_MASK = 8'h01;

	// Frame mode register values.
	localparam logic MODE_ROM = 1'b0;
	localparam logic MODE_PAD = 1'b1;

	// Result status codes.
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_REPAIRED = 2'd1;
	localparam logic [1:0] STATUS_ERROR    = 2'd2;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [15:0] temperature_raw;
		logic [7:0]         computed_crc;
	} result_t;

	// One byte through the CRC, least significant bit first.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
			input logic [7:0] data_in);
		logic [7:0] crc;
		logic       fb;
		crc = crc_in;
		for (int k = 0; k < 8; k++) begin
			fb  = crc[0] ^ data_in[k];
			crc = {1'b0, crc[7:1]};
			if (fb) begin
				crc = crc ^ CRC_POLY;
			end
		end
		return crc;
	endfunction

endpackage

// ===== sv/ocrc_if.sv =====
// ----------------------------------------------------------------------------
// ocrc_if: valid/ready channels of the 1-Wire frame CRC checker
// Received byte channel, result channel and frame mode write channel.
// ----------------------------------------------------------------------------
interface ocrc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_start;

	modport source (output valid, output data_byte, output frame_start, input ready);
	modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface ocrc_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [15:0] temperature_raw;
	logic [7:0]         computed_crc;

	modport source (output valid, output status, output temperature_raw,
		output computed_crc, input ready);
	modport sink (input valid, input status, input temperature_raw,
		input computed_crc, output ready);
endinterface

interface ocrc_cfg_if;
	logic valid;
	logic ready;
	logic frame_mode;

	modport source (output valid, output frame_mode, input ready);
	modport sink (input valid, input frame_mode, output ready);
endinterface

// ===== sv/ocrc_frame_engine.sv =====
// ----------------------------------------------------------------------------
// ocrc_frame_engine: per-byte frame tracking and CRC accumulation
// Holds the byte position, the plain and repaired CRCs and the captured
// temperature bytes, and forms the result on the frame's check byte.
// ----------------------------------------------------------------------------
module ocrc_frame_engine (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           data_byte,
	input  logic                 frame_start,
	input  logic                 frame_mode,
	output logic                 res_valid,
	output ocrc_pkg::result_t    res
);

	logic [3:0] index_q;
	logic [7:0] crc_plain_q;
	logic [7:0] crc_rep_q;
	logic [7:0] temp_lo_q;
	logic [7:0] temp_hi_q;

	logic [3:0] last_idx;
	logic [3:0] idx_eff;
	logic [7:0] crc_plain_eff;
	logic [7:0] crc_rep_eff;
	logic [7:0] rep_byte;
	logic [7:0] crc_plain_nxt;
	logic [7:0] crc_rep_nxt;
	logic       is_body;
	logic       is_check;

	// A start byte restarts the frame at byte 0 with cleared CRCs.
	always_comb begin
		last_idx      = (frame_mode == ocrc_pkg::MODE_PAD) ? ocrc_pkg::PAD_LAST
			: ocrc_pkg::ROM_LAST;
		idx_eff       = frame_start ? 4'd0 : index_q;
		crc_plain_eff = frame_start ? 8'd0 : crc_plain_q;
		crc_rep_eff   = frame_start ? 8'd0 : crc_rep_q;
		is_body       = idx_eff < last_idx;
		is_check      = idx_eff == last_idx;
		rep_byte      = (idx_eff == 4'd0) ? (data_byte | ocrc_pkg::REPAIR_MASK)
			: data_byte;
		crc_plain_nxt = ocrc_pkg::crc8_byte(crc_plain_eff, data_byte);
		crc_rep_nxt   = ocrc_pkg::crc8_byte(crc_rep_eff, rep_byte);
	end

	// Result of the check byte.
	always_comb begin
		res_valid = step && is_check;
		res.computed_crc = crc_plain_eff;
		if (crc_plain_eff == data_byte) begin
			res.status = ocrc_pkg::STATUS_OK;
		end else if (frame_mode == ocrc_pkg::MODE_PAD && crc_rep_eff == data_byte) begin
			res.status = ocrc_pkg::STATUS_REPAIRED;
		end else begin
			res.status = ocrc_pkg::STATUS_ERROR;
		end
		res.temperature_raw = (frame_mode == ocrc_pkg::MODE_PAD)
			? $signed({temp_hi_q, temp_lo_q}) : 16'sd0;
	end

	// Frame position and CRC state; idle bytes leave everything unchanged.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q     <= ocrc_pkg::IDLE_INDEX;
			crc_plain_q <= 8'd0;
			crc_rep_q   <= 8'd0;
		end else if (step) begin
			if (is_body) begin
				index_q     <= idx_eff + 4'd1;
				crc_plain_q <= crc_plain_nxt;
				crc_rep_q   <= crc_rep_nxt;
			end else if (is_check) begin
				index_q     <= ocrc_pkg::IDLE_INDEX;
				crc_plain_q <= crc_plain_eff;
				crc_rep_q   <= crc_rep_eff;
			end else if (frame_start) begin
				index_q     <= idx_eff;
				crc_plain_q <= crc_plain_eff;
				crc_rep_q   <= crc_rep_eff;
			end
		end
	end

	// Temperature bytes are captured from byte 0 and byte 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_lo_q <= 8'd0;
			temp_hi_q <= 8'd0;
		end else if (step && is_body) begin
			if (idx_eff == 4'd0) begin
				temp_lo_q <= data_byte;
			end
			if (idx_eff == 4'd1) begin
				temp_hi_q <= data_byte;
			end
		end
	end

endmodule

// ===== sv/onewire_frame_crc_checker.sv =====
// ----------------------------------------------------------------------------
// onewire_frame_crc_checker: Dallas CRC-8 check of 1-Wire ROM/scratchpad frames
// Path: a check byte passes the input register, then its result is offered from the
// result register. Throughput: one byte per cycle unless a held result waits on
// res.ready; the byte CRC update sits between the input register and the result
// register, and the result register refills as it drains.
// Reset: asynchronous, active low; frame_mode returns to scratchpad and the
// checker waits idle for a frame start.
// ----------------------------------------------------------------------------
module onewire_frame_crc_checker (
	input  logic       clk,
	input  logic       arst_n,
	ocrc_in_if.sink    rx,
	ocrc_out_if.source res,
	ocrc_cfg_if.sink   cfg
);

	logic              frame_mode_q;
	logic              valid_s1;
	logic [7:0]        data_byte_s1;
	logic              frame_start_s1;
	logic              res_valid_q;
	ocrc_pkg::result_t res_q;

	logic              advance;
	logic              eng_valid;
	ocrc_pkg::result_t eng_res;

	// Mode register; writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_mode_q <= ocrc_pkg::MODE_PAD;
		end else if (cfg.valid) begin
			frame_mode_q <= cfg.frame_mode;
		end
	end

	// The input stage moves on whenever the result register is free or draining.
	assign advance  = !res_valid_q || res.ready;
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			data_byte_s1   <= rx.data_byte;
			frame_start_s1 <= rx.frame_start;
		end
	end

	ocrc_frame_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (valid_s1 && advance),
		.data_byte   (data_byte_s1),
		.frame_start (frame_start_s1),
		.frame_mode  (frame_mode_q),
		.res_valid   (eng_valid),
		.res         (eng_res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= eng_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_valid) begin
			res_q <= eng_res;
		end
	end

	assign res.valid           = res_valid_q;
	assign res.status          = res_q.status;
	assign res.temperature_raw = res_q.temperature_raw;
	assign res.computed_crc    = res_q.computed_crc;

endmodule
